// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HMAC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define HMAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== design/hmac_pkg.sv =====
// ----------------------------------------------------------------------------
// hmac_pkg
// Shared types, codes and SHA-256 constants for the HMAC-SHA256 engine.
// ----------------------------------------------------------------------------
package hmac_pkg;

    localparam logic [1:0] OP_KEY = 2'd0;
    localparam logic [1:0] OP_MSG = 2'd1;
    localparam logic [1:0] OP_FIN = 2'd2;

    localparam logic [2:0] SRC_INPUT = 3'd0;
    localparam logic [2:0] SRC_KEY   = 3'd1;
    localparam logic [2:0] SRC_PAD80 = 3'd2;
    localparam logic [2:0] SRC_ZERO  = 3'd3;
    localparam logic [2:0] SRC_LEN   = 3'd4;
    localparam logic [2:0] SRC_INNER = 3'd5;

    localparam logic [1:0] KP_NONE = 2'd0;
    localparam logic [1:0] KP_IPAD = 2'd1;
    localparam logic [1:0] KP_OPAD = 2'd2;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;

    typedef struct packed {
        logic       capture_byte;
        logic       hash_init;
        logic       absorb;
        logic [2:0] src;
        logic [1:0] kpad;
        logic       key_clear;
        logic       key_push;
        logic       key_align;
        logic       key_load;
        logic       save_inner;
        logic       len_capture;
        logic       out_load;
        logic [2:0] word_sel;
    } hmac_cmd_t;

    typedef struct packed {
        logic busy;
        logic at_len_pos;
    } hmac_status_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0:    init_hash = 32'h6a09e667;
            3'd1:    init_hash = 32'hbb67ae85;
            3'd2:    init_hash = 32'h3c6ef372;
            3'd3:    init_hash = 32'ha54ff53a;
            3'd4:    init_hash = 32'h510e527f;
            3'd5:    init_hash = 32'h9b05688c;
            3'd6:    init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98; 6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf; 6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b; 6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4; 6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98; 6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ===== design/hmac_datapath.sv =====
// ----------------------------------------------------------------------------
// hmac_datapath
// Key store, byte window, SHA-256 round unit (one round a cycle), chaining
// value, length and inner digest registers, and the result word register.
// ----------------------------------------------------------------------------
module hmac_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hmac_pkg::hmac_cmd_t    cmd,
    input  logic [7:0]           data_byte,
    output hmac_pkg::hmac_status_t status,
    output logic [31:0]          digest_word
);
    import hmac_pkg::*;

    logic [7:0]   byte_reg;
    logic [511:0] key_reg;
    logic [63:0]  len_reg;
    logic [255:0] inner_reg;
    logic [63:0]  count_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  h_reg [8];
    logic [31:0]  wk_reg [8];
    logic [5:0]   round_reg;
    logic         busy_reg;
    logic         add_reg;
    logic [31:0]  digest_reg;

    logic [7:0]   pad_byte;
    logic [7:0]   absorb_byte;
    logic [31:0]  w_t;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic         start_compress;

    always_comb
    begin
        case (cmd.kpad)
            KP_IPAD: pad_byte = IPAD_BYTE;
            KP_OPAD: pad_byte = OPAD_BYTE;
            default: pad_byte = 8'h00;
        endcase
        case (cmd.src)
            SRC_INPUT: absorb_byte = byte_reg;
            SRC_KEY:   absorb_byte = key_reg[511:504] ^ pad_byte;
            SRC_PAD80: absorb_byte = 8'h80;
            SRC_LEN:   absorb_byte = len_reg[63:56];
            SRC_INNER: absorb_byte = inner_reg[255:248];
            default:   absorb_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        if (round_reg < 6'd16)
        begin
            w_t = w_reg[0];
        end
        else
        begin
            w_t = (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10))
                + w_reg[9]
                + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
                + w_reg[0];
        end
        t1 = wk_reg[7] + (rotr(wk_reg[4], 6) ^ rotr(wk_reg[4], 11) ^ rotr(wk_reg[4], 25))
           + ((wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]))
           + round_k(round_reg) + w_t;
        t2 = (rotr(wk_reg[0], 2) ^ rotr(wk_reg[0], 13) ^ rotr(wk_reg[0], 22))
           + ((wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]));
    end

    // The byte that completes a 64-byte block starts a compression.
    assign start_compress = cmd.absorb && (count_reg[5:0] == 6'd63);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            add_reg   <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            if (cmd.key_clear)
            begin
                key_reg <= '0;
            end
            else if (cmd.key_push)
            begin
                key_reg <= {key_reg[503:0], byte_reg};
            end
            else if (cmd.key_align)
            begin
                key_reg <= {key_reg[503:0], 8'h00};
            end
            else if (cmd.key_load)
            begin
                key_reg <= {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                            h_reg[4], h_reg[5], h_reg[6], h_reg[7], 256'd0};
            end
            else if (cmd.absorb && (cmd.src == SRC_KEY))
            begin
                key_reg <= {key_reg[503:0], key_reg[511:504]};
            end

            if (cmd.hash_init)
            begin
                count_reg <= '0;
            end
            else if (cmd.absorb)
            begin
                count_reg <= count_reg + 64'd1;
            end

            if (cmd.hash_init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= init_hash(3'(i));
                end
            end
            else if (add_reg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + wk_reg[i];
                end
            end

            if (start_compress)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (add_reg)
            begin
                busy_reg <= 1'b0;
                add_reg  <= 1'b0;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    add_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_byte)
        begin
            byte_reg <= data_byte;
        end
        if (cmd.len_capture)
        begin
            len_reg <= {count_reg[60:0], 3'b000};
        end
        else if (cmd.absorb && (cmd.src == SRC_LEN))
        begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
        if (cmd.save_inner)
        begin
            inner_reg <= {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                          h_reg[4], h_reg[5], h_reg[6], h_reg[7]};
        end
        else if (cmd.absorb && (cmd.src == SRC_INNER))
        begin
            inner_reg <= {inner_reg[247:0], 8'h00};
        end
        if (cmd.absorb)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
            end
            w_reg[15] <= {w_reg[15][23:0], absorb_byte};
        end
        else if (busy_reg && !add_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_t;
        end
        if (start_compress)
        begin
            for (int i = 0; i < 8; i++)
            begin
                wk_reg[i] <= h_reg[i];
            end
        end
        else if (busy_reg && !add_reg)
        begin
            wk_reg[0] <= t1 + t2;
            wk_reg[1] <= wk_reg[0];
            wk_reg[2] <= wk_reg[1];
            wk_reg[3] <= wk_reg[2];
            wk_reg[4] <= wk_reg[3] + t1;
            wk_reg[5] <= wk_reg[4];
            wk_reg[6] <= wk_reg[5];
            wk_reg[7] <= wk_reg[6];
        end
        if (cmd.out_load)
        begin
            digest_reg <= h_reg[cmd.word_sel];
        end
    end

    assign status.busy       = busy_reg;
    assign status.at_len_pos = (count_reg[5:0] == 6'd56);
    assign digest_word       = digest_reg;

endmodule

// ===== design/hmac_ctrl.sv =====
// ----------------------------------------------------------------------------
// hmac_ctrl
// Sequencer: key handling, pad block absorption, SHA-256 padding, the inner
// and outer passes and the delivery of the eight result words.
// ----------------------------------------------------------------------------
module hmac_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             operation,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             word_index,
    output logic                   last_word,
    input  hmac_pkg::hmac_status_t status,
    output hmac_pkg::hmac_cmd_t    cmd
);
    import hmac_pkg::*;

    localparam logic [3:0] S_READY    = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_ALIGN    = 4'd2;
    localparam logic [3:0] S_LKEY     = 4'd3;
    localparam logic [3:0] S_IN_BYTE  = 4'd4;
    localparam logic [3:0] S_KPAD     = 4'd5;
    localparam logic [3:0] S_INNER    = 4'd6;
    localparam logic [3:0] S_PAD80    = 4'd7;
    localparam logic [3:0] S_PAD0     = 4'd8;
    localparam logic [3:0] S_PADLEN   = 4'd9;
    localparam logic [3:0] S_PADEND   = 4'd10;
    localparam logic [3:0] S_EMIT     = 4'd11;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SHORT = 2'd1;
    localparam logic [1:0] PH_LONG  = 2'd2;
    localparam logic [1:0] PH_MSG   = 2'd3;

    localparam logic [1:0] CTX_KEYD  = 2'd0;
    localparam logic [1:0] CTX_INNER = 2'd1;
    localparam logic [1:0] CTX_OUTER = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] ctx_reg, ctx_next;
    logic [1:0] op_reg, op_next;
    logic       outer_reg, outer_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [6:0] kcnt_reg, kcnt_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] index_reg, index_next;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        ctx_next       = ctx_reg;
        op_next        = op_reg;
        outer_next     = outer_reg;
        cnt_next       = cnt_reg;
        kcnt_next      = kcnt_reg;
        out_valid_next = out_valid_reg;
        index_next     = index_reg;
        cmd            = '0;
        cmd.src        = SRC_ZERO;
        cmd.kpad       = KP_NONE;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_READY:
            begin
                in_ready = !status.busy;
                if (in_valid && !status.busy)
                begin
                    cmd.capture_byte = 1'b1;
                    op_next          = operation;
                    state_next       = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (op_reg == OP_KEY)
                begin
                    case (phase_reg)
                        PH_SHORT:
                        begin
                            if (kcnt_reg < 7'd64)
                            begin
                                cmd.key_push = 1'b1;
                                kcnt_next    = kcnt_reg + 7'd1;
                                state_next   = S_READY;
                            end
                            else
                            begin
                                // The key outgrows one block: hash it instead.
                                cmd.hash_init = 1'b1;
                                cnt_next      = '0;
                                phase_next    = PH_LONG;
                                state_next    = S_LKEY;
                            end
                        end
                        PH_LONG:
                        begin
                            state_next = S_IN_BYTE;
                        end
                        default:
                        begin
                            cmd.key_clear = 1'b1;
                            kcnt_next     = '0;
                            phase_next    = PH_SHORT;
                        end
                    endcase
                end
                else if ((op_reg == OP_MSG) || (op_reg == OP_FIN))
                begin
                    case (phase_reg)
                        PH_MSG:
                        begin
                            if (op_reg == OP_FIN)
                            begin
                                ctx_next   = CTX_INNER;
                                state_next = S_PAD80;
                            end
                            else
                            begin
                                state_next = S_IN_BYTE;
                            end
                        end
                        PH_LONG:
                        begin
                            ctx_next   = CTX_KEYD;
                            state_next = S_PAD80;
                        end
                        PH_SHORT:
                        begin
                            state_next = S_ALIGN;
                        end
                        default:
                        begin
                            cmd.hash_init = 1'b1;
                            outer_next    = 1'b0;
                            cnt_next      = '0;
                            phase_next    = PH_MSG;
                            state_next    = S_KPAD;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_READY;
                end
            end
            S_ALIGN:
            begin
                // Shift zeros in until the short key sits at the top of the block.
                if (kcnt_reg == 7'd64)
                begin
                    phase_next = PH_IDLE;
                    state_next = S_DISPATCH;
                end
                else
                begin
                    cmd.key_align = 1'b1;
                    kcnt_next     = kcnt_reg + 7'd1;
                end
            end
            S_LKEY:
            begin
                if (!status.busy)
                begin
                    cmd.absorb = 1'b1;
                    cmd.src    = SRC_KEY;
                    cnt_next   = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                    begin
                        state_next = S_IN_BYTE;
                    end
                end
            end
            S_IN_BYTE:
            begin
                if (!status.busy)
                begin
                    cmd.absorb = 1'b1;
                    cmd.src    = SRC_INPUT;
                    state_next = S_READY;
                end
            end
            S_KPAD:
            begin
                if (!status.busy)
                begin
                    cmd.absorb = 1'b1;
                    cmd.src    = SRC_KEY;
                    cmd.kpad   = outer_reg ? KP_OPAD : KP_IPAD;
                    cnt_next   = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                    begin
                        cnt_next = '0;
                        if (outer_reg)
                        begin
                            state_next = S_INNER;
                        end
                        else if (op_reg == OP_FIN)
                        begin
                            ctx_next   = CTX_INNER;
                            state_next = S_PAD80;
                        end
                        else
                        begin
                            state_next = S_IN_BYTE;
                        end
                    end
                end
            end
            S_INNER:
            begin
                if (!status.busy)
                begin
                    cmd.absorb = 1'b1;
                    cmd.src    = SRC_INNER;
                    cnt_next   = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd31)
                    begin
                        ctx_next   = CTX_OUTER;
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80:
            begin
                if (!status.busy)
                begin
                    cmd.len_capture = 1'b1;
                    cmd.absorb      = 1'b1;
                    cmd.src         = SRC_PAD80;
                    state_next      = S_PAD0;
                end
            end
            S_PAD0:
            begin
                if (!status.busy)
                begin
                    if (status.at_len_pos)
                    begin
                        cnt_next   = '0;
                        state_next = S_PADLEN;
                    end
                    else
                    begin
                        cmd.absorb = 1'b1;
                        cmd.src    = SRC_ZERO;
                    end
                end
            end
            S_PADLEN:
            begin
                if (!status.busy)
                begin
                    cmd.absorb = 1'b1;
                    cmd.src    = SRC_LEN;
                    cnt_next   = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd7)
                    begin
                        state_next = S_PADEND;
                    end
                end
            end
            S_PADEND:
            begin
                if (!status.busy)
                begin
                    case (ctx_reg)
                        CTX_KEYD:
                        begin
                            // The long key's digest becomes the held key.
                            cmd.key_load = 1'b1;
                            phase_next   = PH_IDLE;
                            state_next   = S_DISPATCH;
                        end
                        CTX_INNER:
                        begin
                            cmd.save_inner = 1'b1;
                            cmd.hash_init  = 1'b1;
                            outer_next     = 1'b1;
                            cnt_next       = '0;
                            state_next     = S_KPAD;
                        end
                        default:
                        begin
                            cnt_next   = '0;
                            phase_next = PH_IDLE;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.word_sel   = cnt_reg[2:0];
                    out_valid_next = 1'b1;
                    index_next     = cnt_reg[2:0];
                    cnt_next       = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd7)
                    begin
                        state_next = S_READY;
                    end
                end
            end
            default:
            begin
                state_next = S_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_READY;
            phase_reg     <= PH_IDLE;
            ctx_reg       <= CTX_KEYD;
            op_reg        <= OP_KEY;
            outer_reg     <= 1'b0;
            cnt_reg       <= '0;
            kcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            index_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ctx_reg       <= ctx_next;
            op_reg        <= op_next;
            outer_reg     <= outer_next;
            cnt_reg       <= cnt_next;
            kcnt_reg      <= kcnt_next;
            out_valid_reg <= out_valid_next;
            index_reg     <= index_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign word_index = index_reg;
    assign last_word  = (index_reg == 3'd7);

`include "assert_macros.svh"

    `HMAC_ASSERT_NOW(a_ready_not_busy, in_ready, !status.busy)
    `HMAC_ASSERT_NOW(a_emit_source, $rose(out_valid_reg), $past(state_reg == S_EMIT))
    `HMAC_ASSERT_NOW(a_inner_count, state_reg == S_INNER, cnt_reg < 7'd32)
    `HMAC_ASSERT_NEXT(a_len_bytes, state_reg == S_PADLEN && cnt_reg == 7'd7 && !status.busy,
                      state_reg == S_PADEND)

endmodule

// ===== design/hmac_sha256_engine.sv =====
// ----------------------------------------------------------------------------
// hmac_sha256_engine
// HMAC-SHA256 over a byte stream of key bytes, message bytes and a finish.
// ----------------------------------------------------------------------------
// A short key byte passes through the ready and dispatch states (a first byte
// of a new key also clears the held key) and a message byte also through the
// byte-absorb state; every 64th byte fed to the hash starts a compression (one
// SHA-256 round a cycle, then the chaining add). The first message byte after
// a new key first absorbs the 64-byte inner pad block (after aligning a short
// key). A finish runs the inner padding, the outer pad block, the inner digest
// and the outer padding (a finish with no message first absorbs the inner pad
// block as well), and then delivers eight result items, one a cycle while the
// consumer takes them. Each absorbed byte, including padding, passes through
// the byte window.
module hmac_sha256_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import hmac_pkg::*;

    hmac_cmd_t    cmd;
    hmac_status_t status;

    hmac_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_index (word_index),
        .last_word  (last_word),
        .status     (status),
        .cmd        (cmd)
    );

    hmac_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hmac_sha256_engine. A built-in HMAC-SHA256 predictor
// follows every accepted item, and each MAC word delivered is compared with
// the oldest word still expected. Stimulus is a directed opening, then random
// key/message/finish sequences with noise, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import hmac_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int ITEM_TARGET = 200;

    localparam bit [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] START_CHAIN [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {KEY_HELD, KEY_SHORT, KEY_LONG, MSG_ABSORB} mac_phase_t;

    typedef struct {
        bit [31:0] word;
        bit [2:0]  index;
        bit        last;
    } mac_word_t;

    class mac_scoreboard;
        bit [7:0]    key_block [64];
        bit [7:0]    hash_block [64];
        bit [31:0]   chain [8];
        bit [63:0]   hashed_count;
        bit [63:0]   key_count;
        mac_phase_t  phase;
        mac_word_t   mac_words_due [$];
        int          mismatches;

        function new();
            foreach (key_block[i]) key_block[i] = 8'h00;
            foreach (chain[i]) chain[i] = START_CHAIN[i];
            hashed_count = 0;
            key_count = 0;
            phase = KEY_HELD;
            mismatches = 0;
        endfunction

        function bit [31:0] ror32(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            bit [31:0] w [64];
            bit [31:0] a, b, c, d, e, f, g, h, t1, t2;
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (int t = 0; t < 64; t++)
            begin
                if (t < 16)
                    w[t] = {hash_block[4*t], hash_block[4*t+1],
                            hash_block[4*t+2], hash_block[4*t+3]};
                else
                    w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10))
                         + w[t-7]
                         + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                         + w[t-16];
                t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                   + ROUND_CONST[t] + w[t];
                t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        function void restart_hash();
            foreach (chain[i]) chain[i] = START_CHAIN[i];
            hashed_count = 0;
        endfunction

        function void absorb(bit [7:0] v);
            hash_block[hashed_count[5:0]] = v;
            hashed_count++;
            if (hashed_count[5:0] == 6'd0)
                compress();
        endfunction

        function void close_hash();
            int pos;
            bit [63:0] bits;
            pos = hashed_count[5:0];
            bits = hashed_count << 3;
            hash_block[pos++] = 8'h80;
            if (pos > 56)
            begin
                while (pos < 64) hash_block[pos++] = 8'h00;
                compress();
                pos = 0;
            end
            while (pos < 56) hash_block[pos++] = 8'h00;
            for (int i = 0; i < 8; i++)
                hash_block[56+i] = bits[63-8*i -: 8];
            compress();
        endfunction

        function void absorb_key(bit [7:0] pad);
            restart_hash();
            for (int i = 0; i < 64; i++)
                absorb(key_block[i] ^ pad);
        endfunction

        function void open_inner();
            if (phase == KEY_LONG)
            begin
                close_hash();
                foreach (key_block[i]) key_block[i] = 8'h00;
                for (int i = 0; i < 32; i++)
                    key_block[i] = chain[i/4][31-8*(i%4) -: 8];
            end
            absorb_key(IPAD_BYTE);
            phase = MSG_ABSORB;
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] v);
            bit [31:0] inner [8];
            case (op)
                OP_KEY:
                begin
                    if (phase == KEY_HELD || phase == MSG_ABSORB)
                    begin
                        foreach (key_block[i]) key_block[i] = 8'h00;
                        key_count = 0;
                        phase = KEY_SHORT;
                    end
                    if (phase == KEY_SHORT && key_count < 64)
                        key_block[key_count] = v;
                    else if (phase == KEY_SHORT)
                    begin
                        // The key has outgrown one block, so it is hashed from here on.
                        restart_hash();
                        for (int i = 0; i < 64; i++)
                            absorb(key_block[i]);
                        absorb(v);
                        phase = KEY_LONG;
                    end
                    else
                        absorb(v);
                    key_count++;
                end
                OP_MSG:
                begin
                    if (phase != MSG_ABSORB)
                        open_inner();
                    absorb(v);
                end
                OP_FIN:
                begin
                    if (phase != MSG_ABSORB)
                        open_inner();
                    close_hash();
                    inner = chain;
                    absorb_key(OPAD_BYTE);
                    for (int i = 0; i < 32; i++)
                        absorb(inner[i/4][31-8*(i%4) -: 8]);
                    close_hash();
                    phase = KEY_HELD;
                    for (int i = 0; i < 8; i++)
                        mac_words_due.push_back('{chain[i], i[2:0], i == 7});
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [31:0] word, logic [2:0] index, logic last);
            mac_word_t want;
            if (mac_words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected MAC word %h index %0d last %0b", word, index, last);
                return;
            end
            want = mac_words_due.pop_front();
            if (word !== want.word || index !== want.index || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MAC word mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                             want.word, want.index, want.last, word, index, last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = OP_KEY;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    mac_scoreboard sb = new();
    bit calm = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    hmac_sha256_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] v);
        int gap;
        gap = calm ? 0 : int'($urandom_range(0, 4));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_byte <= v;
        do @(posedge clk); while (!in_ready);
        sb.note_item(op, v);
        items_sent++;
    endtask

    // Occasional unused codes are mixed into the bytes.
    task automatic send_noisy(input logic [1:0] op);
        if ($urandom_range(0, 9) == 0)
            send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
        send_item(op, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_sequence(input int key_len, input int msg_len);
        for (int i = 0; i < key_len; i++)
            send_noisy(OP_KEY);
        for (int i = 0; i < msg_len; i++)
        begin
            send_noisy(OP_MSG);
            if ($urandom_range(0, 40) == 0)
                send_item(OP_KEY, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) != 0)
            send_item(OP_FIN, 8'($urandom_range(0, 255)));
    endtask

    // Receiving side: a random stall before each MAC word.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : int'($urandom_range(0, 4));
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_word(digest_word, word_index, last_word);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("hmac_sha256_engine regression: fail");
            $finish;
        end
    end

    initial
    begin
        int key_len, msg_len, pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty key and empty message straight after reset.
        send_item(OP_FIN, 8'hc3);
        send_item(OP_UNUSED, 8'haa);
        send_item(OP_MSG, 8'h00);
        send_item(OP_MSG, 8'hff);
        send_item(OP_FIN, 8'h00);
        send_item(OP_KEY, 8'hff);
        send_item(OP_KEY, 8'h00);
        send_item(OP_KEY, 8'h5a);
        send_item(OP_MSG, 8'h12);
        send_item(OP_MSG, 8'h34);
        // A key byte in mid-message drops the message and starts a fresh key.
        send_item(OP_KEY, 8'ha5);
        send_item(OP_MSG, 8'h01);
        send_item(OP_FIN, 8'hff);
        send_item(OP_MSG, 8'h80);
        send_item(OP_FIN, 8'h3c);
        send_item(OP_UNUSED, 8'h55);
        send_item(OP_FIN, 8'h00);

        // Long key first so that the hashed-key path is always reached.
        send_sequence(66, 3);
        while (items_sent < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)      key_len = 0;
            else if (pick == 7) key_len = 64;
            else if (pick == 8) key_len = $urandom_range(65, 70);
            else if (pick == 9) key_len = $urandom_range(33, 63);
            else                key_len = $urandom_range(1, 32);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       msg_len = 0;
                1:       msg_len = 55;
                2:       msg_len = 56;
                3:       msg_len = $urandom_range(63, 65);
                default: msg_len = $urandom_range(1, 20);
            endcase
            send_sequence(key_len, msg_len);
        end
        calm = 1'b0;
        send_item(OP_FIN, 8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        while (sb.mac_words_due.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        if (sb.mismatches == 0)
            $display("hmac_sha256_engine regression: pass");
        else
            $display("hmac_sha256_engine regression: fail");
        $finish;
    end
endmodule
